// ===== design/text_console_char_engine_defines.svh =====
// Assertion macros for the checker file of the text console engine.
`ifndef TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH
`define TEXT_CONSOLE_CHAR_ENGINE_DEFINES_SVH

// Antecedent and consequent are checked at the same edge; the consequent may carry a delay.
`define TCON_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> cons) \
        else $error(msg);

// The consequent is checked at the edge after the antecedent.
`define TCON_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/tcon_pkg.sv =====
// Shared types and constants of the text console character engine.
`default_nettype none

package tcon_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int CELL_COUNT = COLUMNS * ROWS;

    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = CHAR_W + ATTR_W;
    localparam int TYPE_W = 2;
    localparam int IDX_W  = 11;
    localparam int LOC_W  = 11;

    localparam int COL_W  = $clog2(COLUMNS + 8);
    localparam int ROW_W  = $clog2(ROWS + 1);
    localparam int PROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int ADDR_W = $clog2(CELL_COUNT);
    localparam int LOCC_W = (ADDR_W > LOC_W) ? ADDR_W : LOC_W;

    localparam int TAB_STEP = 8;

    localparam logic [TYPE_W-1:0] REQ_PUT   = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_CLEAR = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_LF        = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_CR        = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd15;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [CHAR_W-1:0] char_code;
        logic [IDX_W-1:0]  cell_index;
    } con_req_t;

    typedef struct packed {
        logic [LOC_W-1:0]  cursor_location;
        logic [CELL_W-1:0] cell_data;
    } con_res_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT,
        ST_FILL,
        ST_CLEAR,
        ST_RD_DIV,
        ST_RD_FIX,
        ST_RD_ADDR,
        ST_RD_DATA,
        ST_FINISH
    } con_state_t;

endpackage

`default_nettype wire

// ===== design/text_console_char_engine.sv =====
// Text console engine: character grid in one RAM, cursor, scrolling and cell reads.
// Sequence: a put runs PUT (then FILL for a lazily blank row), a clear runs CLEAR, and a read
// runs RD_DIV, RD_FIX, RD_ADDR and RD_DATA; each ends in FINISH, from which done is registered.
// Start is taken again in the cycle that done is high, so a new transaction is accepted
// only once the last one has finished.
// Reset is asynchronous and active low; all rows come out blank through row valid bits,
// so there is no clearing pass and the engine leaves reset in the idle state.
`default_nettype none

module text_console_char_engine
    import tcon_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire con_req_t          req,
    output logic                   done,
    output con_res_t               res,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [ATTR_W-1:0] cfg_data
);

    // The grid lives in one RAM indexed by physical row * COLUMNS + column. Scrolling
    // rotates a ring offset (top_reg) instead of moving cells. Each physical row has a
    // valid bit and a blank attribute: a row that is not valid reads as spaces in that
    // attribute. Clear and scroll write no RAM cells but drop valid bits; the first character written
    // into such a row triggers a fill sweep that writes the whole row once.

    localparam int DIV_SHIFT = IDX_W;
    localparam int RECIP     = (1 << DIV_SHIFT) / COLUMNS;
    localparam int PROD_W    = 2 * IDX_W;

    con_state_t state_reg, state_next;

    con_req_t              req_reg;
    logic [ATTR_W-1:0]     attr_reg;
    logic [COL_W-1:0]      col_reg;
    logic [ROW_W-1:0]      row_reg;
    logic [PROW_W-1:0]     top_reg;
    logic [ROWS-1:0]       row_valid_reg;
    logic [ATTR_W-1:0]     row_attr_reg [ROWS];

    logic [PROW_W-1:0]     fill_prow_reg;
    logic [COL_W-1:0]      fill_col_reg;
    logic [COL_W-1:0]      fill_cnt_reg;

    logic [PROD_W-1:0]     prod_reg;
    logic                  in_range_reg;
    logic [PROW_W-1:0]     rd_row_reg;
    logic [COL_W-1:0]      rd_col_reg;
    logic                  rd_valid_reg;
    logic [ATTR_W-1:0]     rd_attr_reg;
    logic [CELL_W-1:0]     rdata_reg;
    logic [CELL_W-1:0]     data_reg;
    logic                  done_reg;
    con_res_t              res_reg;

    logic [CELL_W-1:0]     mem [CELL_COUNT];
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [CELL_W-1:0]     mem_wdata;

    logic [COL_W-1:0]      put_col;
    logic [ROW_W-1:0]      put_row;
    logic                  put_write;
    logic                  put_scroll;
    logic [PROW_W-1:0]     wr_prow;
    logic                  need_fill;
    logic [PROW_W-1:0]     top_inc;

    logic [IDX_W-1:0]      quot_est;
    logic [IDX_W-1:0]      rem_est;
    logic                  quot_fix;
    logic [PROW_W-1:0]     rd_prow;
    logic [LOCC_W-1:0]     loc_full;

    // Logical row to physical row through the ring offset.
    function automatic logic [PROW_W-1:0] phys_row(input logic [PROW_W-1:0] base,
                                                   input logic [PROW_W-1:0] lrow);
        logic [PROW_W:0] sum;
        sum = {1'b0, base} + {1'b0, lrow};
        if (sum >= (PROW_W + 1)'(ROWS))
            sum = sum - (PROW_W + 1)'(ROWS);
        return sum[PROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [PROW_W-1:0] prow,
                                                    input logic [COL_W-1:0]  col);
        return ADDR_W'(ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col));
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign res       = res_reg;

    // Cursor movement for a put transaction, worked out from the current cursor.
    always_comb
    begin
        logic [COL_W-1:0] col_a;
        logic [ROW_W-1:0] row_a;
        logic [ROW_W-1:0] row_b;
        col_a     = col_reg;
        row_a     = row_reg;
        put_write = 1'b0;
        priority if (req_reg.char_code == CH_BACKSPACE && col_reg != '0)
            col_a = col_reg - COL_W'(1);
        else if (req_reg.char_code == CH_TAB)
            col_a = (col_reg + COL_W'(TAB_STEP)) & ~COL_W'(TAB_STEP - 1);
        else if (req_reg.char_code == CH_CR)
            col_a = '0;
        else if (req_reg.char_code == CH_LF)
        begin
            col_a = '0;
            row_a = row_reg + ROW_W'(1);
        end
        else if (req_reg.char_code >= CH_SPACE && !req_reg.char_code[CHAR_W-1])
        begin
            put_write = 1'b1;
            col_a     = col_reg + COL_W'(1);
        end
        else
            put_write = 1'b0;

        // Wrap at the right edge.
        if (col_a >= COL_W'(COLUMNS))
        begin
            put_col = '0;
            row_b   = row_a + ROW_W'(1);
        end
        else
        begin
            put_col = col_a;
            row_b   = row_a;
        end

        // Passing the last line scrolls the grid by one row.
        put_scroll = (row_b >= ROW_W'(ROWS));
        put_row    = put_scroll ? ROW_W'(ROWS - 1) : row_b;
    end

    assign wr_prow   = phys_row(top_reg, row_reg[PROW_W-1:0]);
    assign need_fill = put_write && !row_valid_reg[wr_prow];
    assign top_inc   = (top_reg == PROW_W'(ROWS - 1)) ? '0 : top_reg + PROW_W'(1);

    // Read index to row and column: reciprocal multiply, then one correction step.
    assign quot_est = prod_reg[PROD_W-1:DIV_SHIFT];
    assign rem_est  = req_reg.cell_index - IDX_W'(quot_est * IDX_W'(COLUMNS));
    assign quot_fix = (rem_est >= IDX_W'(COLUMNS));
    assign rd_prow  = phys_row(top_reg, rd_row_reg);

    assign loc_full = LOCC_W'(LOCC_W'(row_reg) * LOCC_W'(COLUMNS) + LOCC_W'(col_reg));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (req.req_type)
                        REQ_PUT:   state_next = ST_PUT;
                        REQ_CLEAR: state_next = ST_CLEAR;
                        REQ_READ:  state_next = ST_RD_DIV;
                        default:   state_next = ST_FINISH;
                    endcase
                end
            end
            ST_PUT:     state_next = need_fill ? ST_FILL : ST_FINISH;
            ST_FILL:
            begin
                if (fill_cnt_reg == COL_W'(COLUMNS - 1))
                    state_next = ST_FINISH;
            end
            ST_CLEAR:   state_next = ST_FINISH;
            ST_RD_DIV:  state_next = ST_RD_FIX;
            ST_RD_FIX:  state_next = ST_RD_ADDR;
            ST_RD_ADDR: state_next = ST_RD_DATA;
            ST_RD_DATA: state_next = ST_FINISH;
            ST_FINISH:  state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    // RAM port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_PUT:
            begin
                mem_addr  = cell_addr(wr_prow, col_reg);
                mem_wdata = {attr_reg, req_reg.char_code};
                mem_we    = put_write && row_valid_reg[wr_prow];
            end
            ST_FILL:
            begin
                // The character lands in its column during the same sweep.
                mem_we   = 1'b1;
                mem_addr = cell_addr(fill_prow_reg, fill_cnt_reg);
                if (fill_cnt_reg == fill_col_reg)
                    mem_wdata = {attr_reg, req_reg.char_code};
                else
                    mem_wdata = {row_attr_reg[fill_prow_reg], CH_SPACE};
            end
            ST_RD_ADDR:
                mem_addr = cell_addr(rd_prow, rd_col_reg);
            default:
                mem_we = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wdata;
        rdata_reg <= mem[mem_addr];
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            attr_reg      <= RESET_ATTR;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            row_valid_reg <= '0;
            for (int i = 0; i < ROWS; i++)
                row_attr_reg[i] <= RESET_ATTR;
            fill_cnt_reg  <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_FINISH);
            if (cfg_valid && cfg_ready)
                attr_reg <= cfg_data;
            unique case (state_reg)
                ST_PUT:
                begin
                    col_reg      <= put_col;
                    row_reg      <= put_row;
                    fill_cnt_reg <= '0;
                    if (put_scroll)
                    begin
                        // The old top row becomes the new, blank bottom row.
                        row_valid_reg[top_reg] <= 1'b0;
                        row_attr_reg[top_reg]  <= attr_reg;
                        top_reg                <= top_inc;
                    end
                end
                ST_FILL:
                begin
                    fill_cnt_reg <= fill_cnt_reg + COL_W'(1);
                    if (fill_cnt_reg == COL_W'(COLUMNS - 1))
                        row_valid_reg[fill_prow_reg] <= 1'b1;
                end
                ST_CLEAR:
                begin
                    row_valid_reg <= '0;
                    for (int i = 0; i < ROWS; i++)
                        row_attr_reg[i] <= attr_reg;
                    top_reg <= '0;
                    col_reg <= '0;
                    row_reg <= '0;
                end
                default:
                    fill_cnt_reg <= fill_cnt_reg;
            endcase
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && start)
        begin
            req_reg  <= req;
            data_reg <= '0;
        end
        unique case (state_reg)
            ST_PUT:
            begin
                fill_prow_reg <= wr_prow;
                fill_col_reg  <= col_reg;
            end
            ST_RD_DIV:
            begin
                prod_reg     <= PROD_W'(req_reg.cell_index) * PROD_W'(RECIP);
                in_range_reg <= (32'(req_reg.cell_index) < 32'(CELL_COUNT));
            end
            ST_RD_FIX:
            begin
                if (quot_fix)
                begin
                    rd_row_reg <= PROW_W'(quot_est + IDX_W'(1));
                    rd_col_reg <= COL_W'(rem_est - IDX_W'(COLUMNS));
                end
                else
                begin
                    rd_row_reg <= PROW_W'(quot_est);
                    rd_col_reg <= COL_W'(rem_est);
                end
            end
            ST_RD_ADDR:
            begin
                rd_valid_reg <= row_valid_reg[rd_prow];
                rd_attr_reg  <= row_attr_reg[rd_prow];
            end
            ST_RD_DATA:
            begin
                if (!in_range_reg)
                    data_reg <= '0;
                else if (rd_valid_reg)
                    data_reg <= rdata_reg;
                else
                    data_reg <= {rd_attr_reg, CH_SPACE};
            end
            ST_FINISH:
            begin
                res_reg.cursor_location <= loc_full[LOC_W-1:0];
                res_reg.cell_data       <= data_reg;
            end
            default:
                prod_reg <= prod_reg;
        endcase
    end

endmodule

`default_nettype wire

// ===== design/tcon_checker.sv =====
// Port-level checker for the text console engine and its bind to the top level.
`default_nettype none
`include "text_console_char_engine_defines.svh"

module tcon_checker
    import tcon_pkg::*;
(
    input wire logic     clk,
    input wire logic     rst_n,
    input wire logic     start,
    input wire logic     busy,
    input wire con_req_t req,
    input wire logic     done,
    input wire con_res_t res
);

    `TCON_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

    `TCON_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transaction did not raise busy")

    `TCON_ASSERT_IMPL(a_done_idle, done, (!busy), "result shown while still busy")

    `TCON_ASSERT_IMPL(a_clear_home, start && !busy && req.req_type == REQ_CLEAR, ##3 (done && res.cursor_location == '0 && res.cell_data == '0), "clear did not home the cursor")

endmodule

bind text_console_char_engine tcon_checker u_tcon_checker (.*);

`default_nettype wire

// ===== test/text_console_char_engine_tb.sv =====
// Self-checking testbench for the text console character engine.
module text_console_char_engine_tb;
    import tcon_pkg::*;

    // A request type that the engine must treat as a no-op.
    localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;
    // Other character codes used by the stimulus.
    localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
    localparam logic [CHAR_W-1:0] CH_ESCAPE = 8'h1B;
    localparam logic [CHAR_W-1:0] CH_DEL    = 8'h7F;
    localparam logic [CHAR_W-1:0] CH_HIGH   = 8'h80;
    localparam logic [CHAR_W-1:0] CH_LETTER = 8'h48;

    // Quiet cycles before the run is declared hung. The slowest legal gap is the longest
    // sender pause plus a put into a lazily blank row.
    localparam int QUIET_LIMIT  = 2000;
    // Settling time after the last result; covers the longest put latency.
    localparam int TAIL_CYCLES  = 4 * COLUMNS;
    localparam int REPORT_LIMIT = 10;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              start     = 1'b0;
    logic              busy;
    con_req_t          req       = '0;
    logic              done;
    con_res_t          res;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [ATTR_W-1:0] cfg_data  = '0;

    text_console_char_engine i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Shadow copy of the console: the character grid, the cursor and the attribute
    // register. It is advanced once per accepted transaction, in acceptance order.
    logic [CELL_W-1:0] shadow_screen [CELL_COUNT];
    int unsigned       shadow_col;
    int unsigned       shadow_row;
    logic [ATTR_W-1:0] shadow_attr;

    // Responses still owed by the engine, oldest first.
    con_res_t    awaited_responses [$];
    int unsigned mismatch_count = 0;
    int unsigned quiet_cycles   = 0;
    // Chance, in percent, that the sender idles after a transaction.
    int unsigned gap_percent    = 0;

    // Blanks take whatever attribute is current when they are written.
    function automatic void blank_cells(int unsigned first, int unsigned last);
        for (int unsigned i = first; i < last; i++)
            shadow_screen[i] = {shadow_attr, CH_SPACE};
    endfunction

    // Applies one character byte to the shadow cursor and grid.
    function automatic void apply_character(logic [CHAR_W-1:0] code);
        if (code == CH_BACKSPACE) begin
            // At column zero a backspace does nothing at all.
            if (shadow_col != 0)
                shadow_col--;
        end else if (code == CH_TAB) begin
            shadow_col = (shadow_col / TAB_STEP + 1) * TAB_STEP;
        end else if (code == CH_CR) begin
            shadow_col = 0;
        end else if (code == CH_LF) begin
            shadow_col = 0;
            shadow_row++;
        end else if (code >= CH_SPACE && code[CHAR_W-1] == 1'b0) begin
            // Printable range includes DEL; the top half is dropped like a negative char.
            shadow_screen[shadow_row * COLUMNS + shadow_col] = {shadow_attr, code};
            shadow_col++;
        end
        // Both a full line and a tab past the last stop wrap to the next line.
        if (shadow_col >= COLUMNS) begin
            shadow_col = 0;
            shadow_row++;
        end
        // Past the last line everything moves up one row and a blank row comes in.
        if (shadow_row >= ROWS) begin
            for (int unsigned i = 0; i < (ROWS - 1) * COLUMNS; i++)
                shadow_screen[i] = shadow_screen[i + COLUMNS];
            blank_cells((ROWS - 1) * COLUMNS, CELL_COUNT);
            shadow_row = ROWS - 1;
        end
    endfunction

    // Works out the response to one request and updates the shadow state.
    function automatic con_res_t console_response(con_req_t item);
        con_res_t outcome = '0;
        case (item.req_type)
            REQ_PUT:
                apply_character(item.char_code);
            REQ_CLEAR:
            begin
                blank_cells(0, CELL_COUNT);
                shadow_col = 0;
                shadow_row = 0;
            end
            REQ_READ:
                // Reads beyond the grid return zero.
                if (item.cell_index < CELL_COUNT)
                    outcome.cell_data = shadow_screen[item.cell_index];
            default:
                ;
        endcase
        outcome.cursor_location = LOC_W'(shadow_row * COLUMNS + shadow_col);
        return outcome;
    endfunction

    function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    endfunction

    // Every cycle with done high carries one response; compare it with the oldest
    // expectation. The receiver cannot hold results off, so there is no stall here.
    always @(posedge clk) begin
        con_res_t want;
        if (rst_n && done === 1'b1) begin
            if (awaited_responses.size() == 0) begin
                flag_mismatch("unexpected response", 0, res);
            end else begin
                want = awaited_responses.pop_front();
                if (res.cursor_location !== want.cursor_location)
                    flag_mismatch("cursor_location", want.cursor_location,
                                  res.cursor_location);
                if (res.cell_data !== want.cell_data)
                    flag_mismatch("cell_data", want.cell_data, res.cell_data);
            end
        end
    end

    // Watchdog: ends the run when no transaction of any kind moves for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge clk);
            if ((start && !busy) || done === 1'b1 || (cfg_valid && cfg_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("text_console_char_engine_tb: done, errors");
        $finish;
    end

    // Presents one request and holds it until the engine takes it. Start is left high
    // afterwards so that back-to-back requests never see it drop and rise in one step;
    // it is lowered only when the sender decides to idle.
    task automatic send_request(input con_req_t item);
        start <= 1'b1;
        req   <= item;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        awaited_responses.push_back(console_response(item));
        if (gap_percent != 0 && $urandom_range(0, 99) < gap_percent) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
    endtask

    task automatic put_byte(input logic [CHAR_W-1:0] code);
        con_req_t item;
        item.req_type   = REQ_PUT;
        item.char_code  = code;
        item.cell_index = IDX_W'($urandom);
        send_request(item);
    endtask

    task automatic read_cell(input logic [IDX_W-1:0] index);
        con_req_t item;
        item.req_type   = REQ_READ;
        item.char_code  = CHAR_W'($urandom);
        item.cell_index = index;
        send_request(item);
    endtask

    task automatic clear_screen();
        con_req_t item;
        item.req_type   = REQ_CLEAR;
        item.char_code  = CHAR_W'($urandom);
        item.cell_index = IDX_W'($urandom);
        send_request(item);
    endtask

    // Stops sending and waits until every outstanding response has come back.
    task automatic drain_results();
        start <= 1'b0;
        while (awaited_responses.size() != 0)
            @(posedge clk);
    endtask

    // The attribute register is only written while the engine has nothing in flight.
    task automatic write_attribute(input logic [ATTR_W-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        shadow_attr = value;
        cfg_valid <= 1'b0;
    endtask

    // Mostly text with line control, reads close behind the cursor so that freshly
    // written and scrolled cells are checked, plus noise bytes, no-op types and rare clears.
    function automatic con_req_t random_request();
        con_req_t    item;
        int unsigned pick;
        int          near;
        pick            = $urandom_range(0, 999);
        item.req_type   = REQ_PUT;
        item.char_code  = CHAR_W'($urandom);
        item.cell_index = IDX_W'($urandom);
        if (pick < 500) begin
            item.char_code = CHAR_W'($urandom_range(CH_SPACE, CH_DEL));
        end else if (pick < 590) begin
            item.char_code = CH_LF;
        end else if (pick < 630) begin
            item.char_code = CH_CR;
        end else if (pick < 680) begin
            item.char_code = CH_TAB;
        end else if (pick < 720) begin
            item.char_code = CH_BACKSPACE;
        end else if (pick < 760) begin
            // Any byte at all: controls, DEL and the ignored upper half.
        end else if (pick < 900) begin
            near = int'(shadow_row * COLUMNS + shadow_col) - int'($urandom_range(0, 2 * COLUMNS));
            item.req_type   = REQ_READ;
            item.cell_index = IDX_W'((near < 0) ? 0 : near);
        end else if (pick < 960) begin
            // Whole index range, including indexes past the end of the grid.
            item.req_type = REQ_READ;
        end else if (pick < 997) begin
            item.req_type = REQ_NONE;
        end else begin
            item.req_type = REQ_CLEAR;
        end
        return item;
    endfunction

    // Reset contents, out-of-range reads, every request type and each cursor control,
    // including backspace at column zero and bytes that must be ignored.
    task automatic test_directed_cases();
        con_req_t noop;
        gap_percent = 40;
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(CELL_COUNT - 1));
        read_cell(IDX_W'(CELL_COUNT));
        read_cell({IDX_W{1'b1}});
        put_byte(CH_LETTER);
        put_byte(CH_DEL);
        put_byte(CH_HIGH);
        put_byte({CHAR_W{1'b1}});
        put_byte(CH_NUL);
        put_byte(CH_ESCAPE);
        put_byte(CH_BACKSPACE);
        put_byte(CH_CR);
        put_byte(CH_BACKSPACE);
        put_byte(CH_TAB);
        put_byte(CH_TAB);
        put_byte(CH_LF);
        put_byte(CH_SPACE);
        noop.req_type   = REQ_NONE;
        noop.char_code  = {CHAR_W{1'b1}};
        noop.cell_index = {IDX_W{1'b1}};
        send_request(noop);
        read_cell(IDX_W'(0));
        read_cell(IDX_W'(1));
        read_cell(IDX_W'(COLUMNS));
        clear_screen();
        read_cell(IDX_W'(1));
    endtask

    // Walks to the right edge with tab stops and text, wraps on a printable character,
    // then wraps again with a tab from the last stop.
    task automatic test_line_wrap();
        gap_percent = 20;
        put_byte(CH_CR);
        repeat (COLUMNS / TAB_STEP - 1) put_byte(CH_TAB);
        repeat (TAB_STEP) put_byte(CHAR_W'($urandom_range(CH_SPACE, CH_DEL)));
        read_cell(IDX_W'(shadow_row * COLUMNS - 1));
        repeat (COLUMNS / TAB_STEP) put_byte(CH_TAB);
    endtask

    // Runs well past the last line so that the grid scrolls several times, then reads
    // the top, the last text row and the blank row that came in at the bottom.
    task automatic test_scroll();
        gap_percent = 30;
        clear_screen();
        repeat (ROWS + 5) begin
            put_byte(CHAR_W'($urandom_range(CH_SPACE, CH_DEL)));
            put_byte(CH_LF);
        end
        read_cell(IDX_W'(0));
        read_cell(IDX_W'((ROWS - 2) * COLUMNS));
        read_cell(IDX_W'((ROWS - 1) * COLUMNS));
        read_cell(IDX_W'(CELL_COUNT - 1));
    endtask

    // A stretch of random traffic; optionally the sender pauses halfway until
    // every outstanding response has arrived.
    task automatic test_random_traffic(input int unsigned count, input int unsigned idle,
                                       input bit pause_midway);
        gap_percent = idle;
        for (int unsigned n = 0; n < count; n++) begin
            if (pause_midway && n == count / 2)
                drain_results();
            send_request(random_request());
        end
    endtask

    initial begin
        shadow_attr = RESET_ATTR;
        shadow_col  = 0;
        shadow_row  = 0;
        blank_cells(0, CELL_COUNT);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_line_wrap();
        // The scroll test starts with a clear, so cleared and scrolled-in blanks carry the new attribute.
        write_attribute('0);
        test_scroll();
        write_attribute('1);
        test_random_traffic(180, 30, 1'b1);
        write_attribute(ATTR_W'($urandom));
        test_random_traffic(180, 0, 1'b0);
        write_attribute(ATTR_W'($urandom));
        test_random_traffic(180, 60, 1'b0);
        write_attribute(ATTR_W'($urandom));
        clear_screen();
        test_random_traffic(180, 15, 1'b1);
        // The last part runs with no idling at all.
        write_attribute(ATTR_W'($urandom));
        test_random_traffic(150, 0, 1'b0);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && awaited_responses.size() == 0)
            $display("text_console_char_engine_tb: done, clean");
        else
            $display("text_console_char_engine_tb: done, errors");
        $finish;
    end

endmodule
